// ===== src/ffar_pkg.sv =====
// ----------------------------------------------------------------------------
// ffar_pkg
// Shared types and constants of the first-fit address range allocator.
// ----------------------------------------------------------------------------
package ffar_pkg;

  localparam int MAX_RANGES_DEF = 64;
  localparam int PAGE_BITS_DEF  = 12;

  localparam int REG_W   = 20;   // zone registers and stored start page
  localparam int LEN_W   = 21;   // stored length in pages, guard included
  localparam int CAND_W  = 26;   // candidate page arithmetic, holds 2^24 and more
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_TOTAL = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
  localparam logic [2:0] ST_NO_SPACE   = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_MISALIGNED = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd5;

  typedef struct packed {
    logic        command;
    logic [31:0] size_bytes;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] range_address;
  } resp_t;

  typedef struct packed {
    logic [REG_W-1:0] start_page;
    logic [LEN_W-1:0] length_pages;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC_CHK,
    S_SCAN,
    S_SHIFT_UP,
    S_WRITE,
    S_FREE_CHK,
    S_SCAN_FREE,
    S_SHIFT_DN
  } state_t;

endpackage

// ===== src/ffar_mem.sv =====
// ----------------------------------------------------------------------------
// ffar_mem
// Range table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffar_mem
  import ffar_pkg::*;
#(
  parameter int MAX_RANGES = MAX_RANGES_DEF
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(MAX_RANGES)-1:0] waddr,
  input  entry_t                        wdata,
  input  logic [$clog2(MAX_RANGES)-1:0] raddr,
  output entry_t                        rdata
);

  entry_t mem [MAX_RANGES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ffar_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffar_ctrl
// Sequencer: first-fit scan, insert shift and delete shift over the table.
// ----------------------------------------------------------------------------
module ffar_ctrl
  import ffar_pkg::*;
#(
  parameter int MAX_RANGES = MAX_RANGES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  req_t                          cmd,
  output logic                          busy,
  output logic                          done,
  output resp_t                         result,
  input  logic [REG_W-1:0]              zone_start_page,
  input  logic [REG_W-1:0]              zone_end_page,
  input  logic [REG_W-1:0]              zone_total_pages,
  output logic                          mem_we,
  output logic [$clog2(MAX_RANGES)-1:0] mem_waddr,
  output entry_t                        mem_wdata,
  output logic [$clog2(MAX_RANGES)-1:0] mem_raddr,
  input  entry_t                        mem_rdata
);

  localparam int IW = $clog2(MAX_RANGES);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_RANGES);
  localparam logic [CAND_W-1:0] SPACE_PAGES = CAND_W'(1) << (32 - PAGE_BITS);
  localparam logic [32:0] PAGE_MASK = (33'd1 << PAGE_BITS) - 33'd1;

  state_t             state, state_next;
  req_t               req, req_next;
  logic [IW-1:0]      idx, idx_next;
  logic [IW-1:0]      sidx, sidx_next;
  logic [IW-1:0]      pos, pos_next;
  logic [CW-1:0]      count, count_next;
  logic [CAND_W-1:0]  cand, cand_next;
  logic [LEN_W-1:0]   len, len_next;
  logic               done_next;
  resp_t              result_next;

  logic [32:0]        pages;
  logic [CAND_W-1:0]  end_first, nxt, cand_up;
  logic [CW-1:0]      idx_inc;
  logic [31:0]        free_page;

  function automatic logic too_far(input logic [CAND_W-1:0] c, input logic [LEN_W-1:0] l,
                                   input logic [REG_W-1:0] zend);
    logic [CAND_W-1:0] e;
    e = c + CAND_W'(l);
    return (e > CAND_W'(zend)) || (e >= SPACE_PAGES);
  endfunction

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    req    <= req_next;
    idx    <= idx_next;
    sidx   <= sidx_next;
    pos    <= pos_next;
    cand   <= cand_next;
    len    <= len_next;
    result <= result_next;
  end

  always_comb begin
    pages     = ({1'b0, req.size_bytes} + PAGE_MASK) >> PAGE_BITS;
    end_first = CAND_W'(mem_rdata.start_page) + CAND_W'(mem_rdata.length_pages);
    nxt       = (end_first > cand) ? end_first : cand;
    cand_up   = cand + CAND_W'(len);
    idx_inc   = {1'b0, idx} + CW'(1);
    free_page = req.address >> PAGE_BITS;
  end

  always_comb begin
    state_next  = state;
    req_next    = req;
    idx_next    = idx;
    sidx_next   = sidx;
    pos_next    = pos;
    count_next  = count;
    cand_next   = cand;
    len_next    = len;
    done_next   = 1'b0;
    result_next = result;
    mem_we      = 1'b0;
    mem_waddr   = pos;
    mem_wdata   = mem_rdata;
    mem_raddr   = idx;

    case (state)
      S_IDLE: begin
        if (start) begin
          req_next   = cmd;
          state_next = (cmd.command == CMD_FREE) ? S_FREE_CHK : S_ALLOC_CHK;
        end
      end

      S_ALLOC_CHK: begin
        len_next  = LEN_W'(pages) + LEN_W'(1);
        cand_next = CAND_W'(zone_start_page);
        idx_next  = '0;
        pos_next  = '0;
        mem_raddr = '0;
        if (pages == 33'd0 || pages > 33'(zone_total_pages)) begin
          done_next   = 1'b1;
          result_next = '{status: ST_BAD_SIZE, range_address: '0};
          state_next  = S_IDLE;
        end else if (count == FULL_COUNT) begin
          done_next   = 1'b1;
          result_next = '{status: ST_FULL, range_address: '0};
          state_next  = S_IDLE;
        end else if (too_far(CAND_W'(zone_start_page), LEN_W'(pages) + LEN_W'(1),
                             zone_end_page)) begin
          done_next   = 1'b1;
          result_next = '{status: ST_NO_SPACE, range_address: '0};
          state_next  = S_IDLE;
        end else if (count == '0) begin
          state_next = S_WRITE;
        end else begin
          state_next = S_SCAN;
        end
      end

      S_SCAN: begin
        if (cand_up <= CAND_W'(mem_rdata.start_page)) begin
          // fits ahead of this entry: open a slot by shifting the tail up
          pos_next   = idx;
          sidx_next  = IW'(count - CW'(1));
          mem_raddr  = IW'(count - CW'(1));
          state_next = S_SHIFT_UP;
        end else begin
          cand_next = nxt;
          if (too_far(nxt, len, zone_end_page)) begin
            done_next   = 1'b1;
            result_next = '{status: ST_NO_SPACE, range_address: '0};
            state_next  = S_IDLE;
          end else if (idx_inc == count) begin
            pos_next   = IW'(count);
            state_next = S_WRITE;
          end else begin
            idx_next  = IW'(idx_inc);
            mem_raddr = IW'(idx_inc);
          end
        end
      end

      S_SHIFT_UP: begin
        mem_we    = 1'b1;
        mem_waddr = sidx + IW'(1);
        mem_wdata = mem_rdata;
        if (sidx == pos) begin
          state_next = S_WRITE;
        end else begin
          sidx_next = sidx - IW'(1);
          mem_raddr = sidx - IW'(1);
        end
      end

      S_WRITE: begin
        mem_we      = 1'b1;
        mem_waddr   = pos;
        mem_wdata   = '{start_page: cand[REG_W-1:0], length_pages: len};
        count_next  = count + CW'(1);
        done_next   = 1'b1;
        result_next = '{status: ST_OK, range_address: 32'(cand) << PAGE_BITS};
        state_next  = S_IDLE;
      end

      S_FREE_CHK: begin
        idx_next  = '0;
        mem_raddr = '0;
        if ((33'(req.address) & PAGE_MASK) != 33'd0) begin
          done_next   = 1'b1;
          result_next = '{status: ST_MISALIGNED, range_address: '0};
          state_next  = S_IDLE;
        end else if (count == '0) begin
          done_next   = 1'b1;
          result_next = '{status: ST_NOT_FOUND, range_address: '0};
          state_next  = S_IDLE;
        end else begin
          state_next = S_SCAN_FREE;
        end
      end

      S_SCAN_FREE: begin
        mem_raddr = IW'(idx_inc);
        if (32'(mem_rdata.start_page) == free_page && mem_rdata.length_pages != '0) begin
          if (idx_inc == count) begin
            count_next  = count - CW'(1);
            done_next   = 1'b1;
            result_next = '{status: ST_OK, range_address: '0};
            state_next  = S_IDLE;
          end else begin
            sidx_next  = idx;
            state_next = S_SHIFT_DN;
          end
        end else if (idx_inc == count) begin
          done_next   = 1'b1;
          result_next = '{status: ST_NOT_FOUND, range_address: '0};
          state_next  = S_IDLE;
        end else begin
          idx_next = IW'(idx_inc);
        end
      end

      S_SHIFT_DN: begin
        // data of entry sidx+1 is on the read port; pull it down one slot
        mem_we    = 1'b1;
        mem_waddr = sidx;
        mem_wdata = mem_rdata;
        mem_raddr = sidx + IW'(2);
        if (({1'b0, sidx} + CW'(2)) == count) begin
          count_next  = count - CW'(1);
          done_next   = 1'b1;
          result_next = '{status: ST_OK, range_address: '0};
          state_next  = S_IDLE;
        end else begin
          sidx_next = sidx + IW'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/first_fit_address_range_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_address_range_allocator_top
// First-fit allocator of page-granular virtual address ranges, table sorted
// by start page and held in a single synchronous memory.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------
//  request   | start, busy (taken when    | cmd (req_t)
//            |   start & !busy)           |
//  response  | done (one-cycle strobe)    | result (resp_t)
//  config    | cfg_we                     | cfg_index, cfg_data
//
// An allocate or a free scans entries (one per cycle through the memory read
// port) and then shifts entries for an insert or delete (one per cycle, read
// and write ports working together). The entries scanned and the entries
// shifted together never exceed MAX_RANGES.
// Reset clears the entry count and the sequencer; table contents need no
// clearing since only entries below the count are ever used.
// The receiver cannot stall: done is a single-cycle pulse, and a new request
// may be taken in the same cycle that done is shown.
// ----------------------------------------------------------------------------
module first_fit_address_range_allocator_top
  import ffar_pkg::*;
#(
  parameter int MAX_RANGES = MAX_RANGES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  req_t                 cmd,
  output logic                 busy,
  output logic                 done,
  output resp_t                result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam int IW = $clog2(MAX_RANGES);

  // zone configuration, to be written only while idle (not enforced here)
  logic [REG_W-1:0] zone_start_page;
  logic [REG_W-1:0] zone_end_page;
  logic [REG_W-1:0] zone_total_pages;

  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_start_page  <= '0;
      zone_end_page    <= '1;
      zone_total_pages <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ZONE_START: zone_start_page  <= cfg_data;
        CFG_ZONE_END:   zone_end_page    <= cfg_data;
        CFG_ZONE_TOTAL: zone_total_pages <= cfg_data;
        default: ;   // unused index, write dropped
      endcase
    end
  end

  ffar_ctrl #(
    .MAX_RANGES (MAX_RANGES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .cmd              (cmd),
    .busy             (busy),
    .done             (done),
    .result           (result),
    .zone_start_page  (zone_start_page),
    .zone_end_page    (zone_end_page),
    .zone_total_pages (zone_total_pages),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata)
  );

  // range table: start page and length of each held range
  ffar_mem #(
    .MAX_RANGES (MAX_RANGES)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
